// ===== hdl/fhpg_pkg.sv =====
package fhpg_pkg;

  // Default build values.
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;

  // Width of the CORDIC x, y and z datapath.
  localparam int XY_W = 34;

  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [XY_W-1:0] ONE_Q30  = 34'sd1073741824;
  localparam logic signed [XY_W-1:0] HALF_TURN_Q = 34'sd536870912;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  // Quadrant codes after angle reduction.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [0:MAX_STAGES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85005780, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Sideband of one item carried along the CORDIC chain.
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               is_right;
    logic               is_left;
    logic [1:0]         quad;
  } item_t;

  // Result of one item leaving the geometry pipeline.
  typedef struct packed {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic               proj;
    logic               known;
  } result_t;

endpackage

// ===== hdl/fhpg_ifs.sv =====
interface fhpg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic [7:0]         stance_code;
  logic [15:0]        heading;
  logic signed [31:0] mass_x;
  logic signed [31:0] mass_y;
  logic signed [31:0] foot_x;
  logic signed [31:0] foot_y;

  modport source(output valid, target_x, target_y, stance_code, heading, mass_x, mass_y,
                 foot_x, foot_y, input ready);
  modport sink(input valid, target_x, target_y, stance_code, heading, mass_x, mass_y,
               foot_x, foot_y, output ready);
endinterface

interface fhpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] guarded_x;
  logic signed [31:0] guarded_y;
  logic               projected;

  modport source(output valid, guarded_x, guarded_y, projected, input ready);
  modport sink(input valid, guarded_x, guarded_y, projected, output ready);
endinterface

// ===== hdl/foot_halfplane_guard.sv =====
// An accepted input beat passes through the chain of CORDIC cells and then the geometry stages to its result beat.
// Throughput: one item per cycle; the whole pipeline moves together and holds
// only while the output register is full and the sink is not ready.
// Reset (synchronous, active low) empties the pipeline and sets the stance codes
// to 0 and 1 and the line offset to 0.
module foot_halfplane_guard #(
  parameter int ANGLE_BITS    = fhpg_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = fhpg_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fhpg_in_if.sink     in_ch,
  fhpg_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int W = fhpg_pkg::XY_W;
  localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  // Configuration registers.
  logic [7:0]         left_code_r;
  logic [7:0]         right_code_r;
  logic signed [31:0] line_offset_r;
  logic [1:0]         reg_idx;

  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_code_r   <= 8'd0;
      right_code_r  <= 8'd1;
      line_offset_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        fhpg_pkg::REG_LEFT:   left_code_r   <= cfg_pwdata[7:0];
        fhpg_pkg::REG_RIGHT:  right_code_r  <= cfg_pwdata[7:0];
        fhpg_pkg::REG_OFFSET: line_offset_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fhpg_pkg::REG_LEFT:   cfg_prdata = {24'd0, left_code_r};
      fhpg_pkg::REG_RIGHT:  cfg_prdata = {24'd0, right_code_r};
      fhpg_pkg::REG_OFFSET: cfg_prdata = line_offset_r;
      default:              cfg_prdata = '0;
    endcase
  end

  // Pipeline advance: everything moves unless a finished result is stuck.
  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Angle reduction to a quadrant and a residual of at most an eighth turn.
  logic [31:0] turn, turn_rot;
  fhpg_pkg::item_t item_in;

  assign turn     = (32'(in_ch.heading) & ANGLE_MASK) << (32 - ANGLE_BITS);
  assign turn_rot = turn + 32'h2000_0000;

  always_comb begin
    item_in.tx       = in_ch.target_x;
    item_in.ty       = in_ch.target_y;
    item_in.mx       = in_ch.mass_x;
    item_in.my       = in_ch.mass_y;
    item_in.fx       = in_ch.foot_x;
    item_in.fy       = in_ch.foot_y;
    item_in.is_right = (in_ch.stance_code == right_code_r);
    item_in.is_left  = (in_ch.stance_code == left_code_r);
    item_in.quad     = turn_rot[31:30];
  end

  // Chain of CORDIC cells.
  logic                vld [0:CORDIC_STAGES];
  logic signed [W-1:0] cx  [0:CORDIC_STAGES];
  logic signed [W-1:0] cy  [0:CORDIC_STAGES];
  logic signed [W-1:0] cz  [0:CORDIC_STAGES];
  fhpg_pkg::item_t     cit [0:CORDIC_STAGES];

  assign vld[0] = in_ch.valid;
  assign cx[0]  = fhpg_pkg::GAIN_Q30;
  assign cy[0]  = '0;
  assign cz[0]  = $signed({4'b0000, turn_rot[29:0]}) - fhpg_pkg::HALF_TURN_Q;
  assign cit[0] = item_in;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    fhpg_cordic_cell #(.STAGE(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (vld[i]),
      .in_x    (cx[i]),
      .in_y    (cy[i]),
      .in_z    (cz[i]),
      .in_item (cit[i]),
      .vld_r   (vld[i+1]),
      .x_r     (cx[i+1]),
      .y_r     (cy[i+1]),
      .z_r     (cz[i+1]),
      .item_r  (cit[i+1])
    );
  end

  // Guard line geometry.
  fhpg_pkg::result_t res;

  fhpg_geom u_geom (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (vld[CORDIC_STAGES]),
    .in_x        (cx[CORDIC_STAGES]),
    .in_y        (cy[CORDIC_STAGES]),
    .in_item     (cit[CORDIC_STAGES]),
    .line_offset (line_offset_r),
    .out_vld     (out_ch.valid),
    .res         (res)
  );

  assign out_ch.guarded_x = res.gx;
  assign out_ch.guarded_y = res.gy;
  assign out_ch.projected = res.proj;

  // Checks.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_unknown_no_proj: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.projected |-> res.known)
    else $error("projection with an unknown stance code");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld[CORDIC_STAGES]) && $stable(res))
    else $error("pipeline moved while stalled");

  a_no_proj_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !res.known |-> !out_ch.projected)
    else $error("unknown code item flagged as projected");

endmodule

// ===== hdl/fhpg_cordic_cell.sv =====
module fhpg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [fhpg_pkg::XY_W-1:0]    in_x,
  input  logic signed [fhpg_pkg::XY_W-1:0]    in_y,
  input  logic signed [fhpg_pkg::XY_W-1:0]    in_z,
  input  fhpg_pkg::item_t                     in_item,
  output logic                                vld_r,
  output logic signed [fhpg_pkg::XY_W-1:0]    x_r,
  output logic signed [fhpg_pkg::XY_W-1:0]    y_r,
  output logic signed [fhpg_pkg::XY_W-1:0]    z_r,
  output fhpg_pkg::item_t                     item_r
);

  localparam logic signed [fhpg_pkg::XY_W-1:0] ATAN =
    $signed({2'b00, fhpg_pkg::ATAN_TURNS[STAGE]});

  logic signed [fhpg_pkg::XY_W-1:0] x_nxt;
  logic signed [fhpg_pkg::XY_W-1:0] y_nxt;
  logic signed [fhpg_pkg::XY_W-1:0] z_nxt;

  // One rotation step, direction set by the sign of the residual angle.
  always_comb begin
    if (in_z >= 0) begin
      x_nxt = in_x - (in_y >>> STAGE);
      y_nxt = in_y + (in_x >>> STAGE);
      z_nxt = in_z - ATAN;
    end else begin
      x_nxt = in_x + (in_y >>> STAGE);
      y_nxt = in_y - (in_x >>> STAGE);
      z_nxt = in_z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      item_r <= in_item;
    end
  end

endmodule

// ===== hdl/fhpg_geom.sv =====
module fhpg_geom (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic signed [fhpg_pkg::XY_W-1:0] in_x,
  input  logic signed [fhpg_pkg::XY_W-1:0] in_y,
  input  fhpg_pkg::item_t                  in_item,
  input  logic signed [31:0]               line_offset,
  output logic                             out_vld,
  output fhpg_pkg::result_t                res
);

  localparam logic signed [63:0] RND64 = 64'sd536870912;
  localparam logic signed [65:0] RND66 = 66'sd536870912;
  localparam logic signed [67:0] RND68 = 68'sd536870912;

  logic [6:0] v_r;

  // Stage 0: clamp and quadrant mapping.
  logic signed [fhpg_pkg::XY_W-1:0] xc, yc;
  logic signed [31:0] c_nxt, s_nxt, c0_r, s0_r;
  fhpg_pkg::item_t it0_r;

  always_comb begin
    xc = in_x;
    yc = in_y;
    if (in_x > fhpg_pkg::ONE_Q30) xc = fhpg_pkg::ONE_Q30;
    if (in_x < -fhpg_pkg::ONE_Q30) xc = -fhpg_pkg::ONE_Q30;
    if (in_y > fhpg_pkg::ONE_Q30) yc = fhpg_pkg::ONE_Q30;
    if (in_y < -fhpg_pkg::ONE_Q30) yc = -fhpg_pkg::ONE_Q30;
    case (in_item.quad)
      fhpg_pkg::QUAD_0: begin
        c_nxt = 32'(xc);
        s_nxt = 32'(yc);
      end
      fhpg_pkg::QUAD_1: begin
        c_nxt = 32'(-yc);
        s_nxt = 32'(xc);
      end
      fhpg_pkg::QUAD_2: begin
        c_nxt = 32'(-xc);
        s_nxt = 32'(-yc);
      end
      default: begin
        c_nxt = 32'(yc);
        s_nxt = 32'(-xc);
      end
    endcase
  end

  // Stage 1: anchor cross product and offset products.
  logic signed [32:0] dx, dy;
  logic signed [64:0] pa_r, pb_r;
  logic signed [63:0] onx_r, ony_r;
  logic signed [31:0] c1_r, s1_r;
  fhpg_pkg::item_t it1_r;

  assign dx = 33'(it0_r.fx) - 33'(it0_r.mx);
  assign dy = 33'(it0_r.fy) - 33'(it0_r.my);

  // Stage 2: pick the anchor and shift it across the heading.
  logic               use_foot;
  logic signed [33:0] ox, oy;
  logic signed [31:0] ax_nxt, ay_nxt, ax_r, ay_r, c2_r, s2_r;
  fhpg_pkg::item_t it2_r;

  always_comb begin
    use_foot = (it1_r.is_right && (pa_r > pb_r)) || (it1_r.is_left && (pa_r < pb_r));
    ox = 34'((onx_r + RND64) >>> 30);
    oy = 34'((ony_r + RND64) >>> 30);
    if (!it1_r.is_right) begin
      ox = -ox;
      oy = -oy;
    end
    ax_nxt = 32'(34'(use_foot ? it1_r.fx : it1_r.mx) + ox);
    ay_nxt = 32'(34'(use_foot ? it1_r.fy : it1_r.my) + oy);
  end

  // Stage 3: side test products of the target against the line.
  logic signed [32:0] vx, vy;
  logic signed [64:0] qa_r, qb_r;
  logic signed [31:0] c3_r, s3_r;
  fhpg_pkg::item_t it3_r;

  assign vx = 33'(it2_r.tx) - 33'(ax_r);
  assign vy = 33'(it2_r.ty) - 33'(ay_r);

  // Stage 4: distance to the line and the projection decision.
  logic signed [65:0] diff;
  logic signed [35:0] k_r;
  logic               proj4_r;
  logic signed [31:0] c4_r, s4_r;
  fhpg_pkg::item_t it4_r;

  assign diff = 66'(qa_r) - 66'(qb_r);

  // Stage 5: correction vector.
  logic signed [67:0] kx_r, ky_r;
  logic               proj5_r;
  fhpg_pkg::item_t it5_r;

  // Stage 6: output register.
  logic signed [67:0] rx, ry;
  assign rx = (kx_r + RND68) >>> 30;
  assign ry = (ky_r + RND68) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r    <= c_nxt;
      s0_r    <= s_nxt;
      it0_r   <= in_item;

      pa_r    <= 65'(c0_r) * 65'(dy);
      pb_r    <= 65'(s0_r) * 65'(dx);
      onx_r   <= 64'(line_offset) * 64'(-s0_r);
      ony_r   <= 64'(line_offset) * 64'(c0_r);
      c1_r    <= c0_r;
      s1_r    <= s0_r;
      it1_r   <= it0_r;

      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      c2_r    <= c1_r;
      s2_r    <= s1_r;
      it2_r   <= it1_r;

      qa_r    <= 65'(c2_r) * 65'(vy);
      qb_r    <= 65'(s2_r) * 65'(vx);
      c3_r    <= c2_r;
      s3_r    <= s2_r;
      it3_r   <= it2_r;

      k_r     <= 36'((diff + RND66) >>> 30);
      proj4_r <= (it3_r.is_right && (qa_r < qb_r)) || (it3_r.is_left && (qa_r > qb_r));
      c4_r    <= c3_r;
      s4_r    <= s3_r;
      it4_r   <= it3_r;

      kx_r    <= 68'(k_r) * 68'(-s4_r);
      ky_r    <= 68'(k_r) * 68'(c4_r);
      proj5_r <= proj4_r;
      it5_r   <= it4_r;

      res.gx    <= proj5_r ? 32'(68'(it5_r.tx) - rx) : it5_r.tx;
      res.gy    <= proj5_r ? 32'(68'(it5_r.ty) - ry) : it5_r.ty;
      res.proj  <= proj5_r;
      res.known <= it5_r.is_right || it5_r.is_left;
    end
  end

  assign out_vld = v_r[6];

endmodule
